FILE: rtl/core/greedy_box_nms_top_assert.svh
// assertion macros for the greedy box nms block
`ifndef GREEDY_BOX_NMS_TOP_ASSERT_SVH
`define GREEDY_BOX_NMS_TOP_ASSERT_SVH

// same-cycle implication, off while reset is high
`define GBN_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("greedy_box_nms_top: check failed");

// next-cycle implication, off while reset is high
`define GBN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("greedy_box_nms_top: check failed");

`endif

FILE: rtl/core/gbn_pkg.sv
`default_nettype none

package gbn_pkg;

  // field widths
  localparam int CoordW  = 15;
  localparam int SizeW   = 14;
  localparam int AreaW   = 2 * SizeW;
  localparam int ThreshW = 9;
  localparam int IndexW  = 10;
  localparam int TotalW  = 7;

  // stream word widths
  localparam int InDataW  = 64;
  localparam int OutDataW = 24;

  // one stored box: {area, height, width, top, left}
  localparam int KeptW = 2 * CoordW + 2 * SizeW + AreaW;

  // threshold after reset, about 0.6 in units of 1/256
  localparam logic [ThreshW-1:0] ThreshReset = 9'd154;

  // compare pipeline behind the store read
  localparam int PipeDepth = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } gbn_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } gbn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic issue_last;
    logic pipe_busy;
    logic out_hold;
  } gbn_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/gbn_ram.sv
`default_nettype none

module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gbn_ctrl.sv
`default_nettype none

module gbn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire gbn_pkg::gbn_stat_t stat,
  output gbn_pkg::gbn_cmd_t      cmd
);

  gbn_pkg::gbn_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gbn_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = gbn_pkg::ST_PREP;
      end
      gbn_pkg::ST_PREP: begin
        state_next = stat.count_zero ? gbn_pkg::ST_COMMIT : gbn_pkg::ST_SCAN;
      end
      gbn_pkg::ST_SCAN: begin
        if (stat.issue_last) state_next = gbn_pkg::ST_DRAIN;
      end
      gbn_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = gbn_pkg::ST_COMMIT;
      end
      gbn_pkg::ST_COMMIT: begin
        if (!stat.out_hold) state_next = gbn_pkg::ST_IDLE;
      end
      default: begin
        state_next = gbn_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      gbn_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      gbn_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      gbn_pkg::ST_COMMIT: begin
        cmd.commit = !stat.out_hold;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/gbn_dpath.sv
`default_nettype none

module gbn_dpath #(
  parameter int MAX_KEPT  = 64,
  parameter int MAX_BOXES = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire gbn_pkg::gbn_cmd_t                   cmd,
  output gbn_pkg::gbn_stat_t                       stat,
  input  wire logic [gbn_pkg::InDataW-1:0]         s_tdata,
  input  wire logic                                s_tlast,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [gbn_pkg::OutDataW-1:0]        m_tdata,
  output logic                                     m_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [gbn_pkg::ThreshW-1:0]         cfg_data
);

  localparam int AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW  = $clog2(MAX_KEPT + 1);
  localparam int FPW = $clog2(MAX_BOXES);
  localparam int CrdW = gbn_pkg::CoordW;
  localparam int SzW  = gbn_pkg::SizeW;
  localparam int ArW  = gbn_pkg::AreaW;
  localparam int PD   = gbn_pkg::PipeDepth;

  // current box
  logic signed [CrdW-1:0] box_left, box_top;
  logic [SzW-1:0]         box_width, box_height;
  logic                   box_last;
  logic [ArW-1:0]         area_q;

  logic [gbn_pkg::ThreshW-1:0] thresh;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  kept_count;
  logic [FPW-1:0] frame_pos;
  logic           suppress;
  logic [PD-1:0]  pv;

  // store port
  logic [gbn_pkg::KeptW-1:0] wr_data, rd_data;
  logic                      room, store_ok;
  logic [CW-1:0]             count_new;

  // stored fields
  logic signed [CrdW-1:0] k_left, k_top;
  logic [SzW-1:0]         k_width, k_height;
  logic [ArW-1:0]         k_area;

  // stage registers
  logic signed [CrdW:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [CrdW:0] end_x, end_y, k_end_x, k_end_y;
  logic [ArW:0]         sum_b, sum_c, sum_d;
  logic [SzW-1:0]       ix, iy;
  logic [CrdW:0]        dx, dy;
  logic [ArW-1:0]       inter_c, inter_d, inter_e;
  logic [ArW:0]         uni_d;
  logic [gbn_pkg::ThreshW+ArW:0] prod_e;
  logic                 hit;

  logic [FPW+gbn_pkg::IndexW-1:0] pos_ext;
  logic [CW+gbn_pkg::TotalW-1:0]  cnt_ext;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= gbn_pkg::ThreshReset;
    end else if (cfg_we) begin
      thresh <= cfg_data;
    end
  end

  // capture the incoming box
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      box_left   <= s_tdata[CrdW-1:0];
      box_top    <= s_tdata[2*CrdW-1:CrdW];
      box_width  <= s_tdata[2*CrdW+SzW-1:2*CrdW];
      box_height <= s_tdata[2*CrdW+2*SzW-1:2*CrdW+SzW];
      box_last   <= s_tlast;
    end
  end

  // own area, registered in the cycle after capture
  always_ff @(posedge clk) begin
    area_q <= box_width * box_height;
  end

  // store read address
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_addr <= '0;
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + AW'(1);
    end
  end

  assign room      = kept_count < CW'(MAX_KEPT);
  assign store_ok  = !suppress && room;
  assign count_new = kept_count + CW'(store_ok);
  assign wr_data   = {area_q, box_height, box_width, box_top, box_left};

  gbn_ram #(
    .WIDTH (gbn_pkg::KeptW),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.commit && store_ok),
    .wr_addr (kept_count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign k_left   = rd_data[CrdW-1:0];
  assign k_top    = rd_data[2*CrdW-1:CrdW];
  assign k_width  = rd_data[2*CrdW+SzW-1:2*CrdW];
  assign k_height = rd_data[2*CrdW+2*SzW-1:2*CrdW+SzW];
  assign k_area   = rd_data[gbn_pkg::KeptW-1:2*CrdW+2*SzW];

  // valid bits of the compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[PD-2:0], cmd.issue};
    end
  end

  // edges of both rectangles
  assign end_x   = $signed({box_left[CrdW-1], box_left}) + $signed({1'b0, box_width});
  assign end_y   = $signed({box_top[CrdW-1], box_top}) + $signed({1'b0, box_height});
  assign k_end_x = $signed({k_left[CrdW-1], k_left}) + $signed({1'b0, k_width});
  assign k_end_y = $signed({k_top[CrdW-1], k_top}) + $signed({1'b0, k_height});

  // stage 1: span limits and area sum
  always_ff @(posedge clk) begin
    lo_x  <= (box_left > k_left) ? {box_left[CrdW-1], box_left} : {k_left[CrdW-1], k_left};
    lo_y  <= (box_top > k_top) ? {box_top[CrdW-1], box_top} : {k_top[CrdW-1], k_top};
    hi_x  <= (end_x < k_end_x) ? end_x : k_end_x;
    hi_y  <= (end_y < k_end_y) ? end_y : k_end_y;
    sum_b <= {1'b0, area_q} + {1'b0, k_area};
  end

  // stage 2: overlap per axis, never beyond the shorter side
  assign dx = hi_x - lo_x;
  assign dy = hi_y - lo_y;
  always_ff @(posedge clk) begin
    ix    <= (hi_x > lo_x) ? dx[SzW-1:0] : '0;
    iy    <= (hi_y > lo_y) ? dy[SzW-1:0] : '0;
    sum_c <= sum_b;
  end

  // stage 3: intersection
  always_ff @(posedge clk) begin
    inter_c <= ix * iy;
    sum_d   <= sum_c;
  end

  // stage 4: union
  always_ff @(posedge clk) begin
    uni_d   <= sum_d - {1'b0, inter_c};
    inter_d <= inter_c;
  end

  // stage 5: threshold times union
  always_ff @(posedge clk) begin
    prod_e  <= thresh * uni_d;
    inter_e <= inter_d;
  end

  // stage 6: inter*256 against threshold*union
  assign hit = {2'b00, inter_e, 8'b0} > prod_e;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      suppress <= 1'b0;
    end else if (pv[PD-1] && hit) begin
      suppress <= 1'b1;
    end
  end

  // store count and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      frame_pos  <= '0;
    end else if (cmd.commit) begin
      if (box_last) begin
        kept_count <= '0;
        frame_pos  <= '0;
      end else begin
        kept_count <= count_new;
        frame_pos  <= (frame_pos == FPW'(MAX_BOXES - 1)) ? '0 : frame_pos + FPW'(1);
      end
    end
  end

  assign pos_ext = {{gbn_pkg::IndexW{1'b0}}, frame_pos};
  assign cnt_ext = {{gbn_pkg::TotalW{1'b0}}, count_new};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {5'b0, !suppress && !room, cnt_ext[gbn_pkg::TotalW-1:0],
                  pos_ext[gbn_pkg::IndexW-1:0], !suppress};
      m_tlast <= box_last;
    end
  end

  // status
  assign stat.count_zero = (kept_count == '0);
  assign stat.issue_last = (CW'(rd_addr) == kept_count - CW'(1));
  assign stat.pipe_busy  = |pv;
  assign stat.out_hold   = m_tvalid && !m_tready;

endmodule

`default_nettype wire

FILE: rtl/core/greedy_box_nms_top.sv
// channel  dir  signals                       word
// s        in   s_tvalid s_tready s_tdata s_tlast  one box, tlast ends the frame
// m        out  m_tvalid m_tready m_tdata m_tlast  one verdict per box
// cfg      in   cfg_we cfg_data                    overlap threshold write
//
// each box is compared against the n stored boxes (n up to MAX_KEPT):
// the store's single read port feeds one stored box per cycle into a six-stage compare.
// while the store is empty, a box skips the compare scan.
// rst is synchronous, active high; it empties the store and sets the threshold to 154.
// a new box is taken while the previous verdict waits in the output register;
// a stalled output holds the following box in its final step.
`default_nettype none

module greedy_box_nms_top #(
  parameter int MAX_KEPT  = 64,
  parameter int MAX_BOXES = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // box_left, box_top, box_width, box_height
  input  wire logic [gbn_pkg::InDataW-1:0]       s_tdata,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // keep, box_index, kept_total, store_full
  output logic      [gbn_pkg::OutDataW-1:0]      m_tdata,
  output logic                                   m_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [gbn_pkg::ThreshW-1:0]       cfg_data
);

  gbn_pkg::gbn_cmd_t  cmd;
  gbn_pkg::gbn_stat_t stat;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbn_dpath #(
    .MAX_KEPT  (MAX_KEPT),
    .MAX_BOXES (MAX_BOXES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

endmodule

`default_nettype wire

FILE: rtl/core/gbn_checker.sv
`default_nettype none

`include "greedy_box_nms_top_assert.svh"

module gbn_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [gbn_pkg::OutDataW-1:0]  m_tdata,
  input wire logic                          m_tlast
);

  // stalled verdict holds
  `GBN_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // one box in flight: ready drops after a box is taken
  `GBN_ASSERT_NEXT(a_one_box, clk, rst, s_tvalid && s_tready, !s_tready)

  // a full store only ever goes with a kept box
  `GBN_ASSERT_NOW(a_full_kept, clk, rst, m_tvalid && m_tdata[18], m_tdata[0])

endmodule

bind greedy_box_nms_top gbn_checker u_gbn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
